// ----- rtl/spq_pkg.sv -----
// ---------------------------------------------------------------------------
// spq_pkg: shared types and constants of the sorted priority event queue
// Request and response structs, operation and error codes, controller state
// and the command and status groups between controller and datapath.
// ---------------------------------------------------------------------------
package spq_pkg;

  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int DEF_KEY_BITS    = 32;

  localparam int FIELD_KEY_BITS = 32;
  localparam int FIELD_TAG_BITS = 16;
  localparam int FIELD_OCC_BITS = 5;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_POP    = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_EMPTY = 2'd1,
    ERR_FULL  = 2'd2
  } err_t;

  typedef struct packed {
    op_t                       opcode;
    logic [FIELD_KEY_BITS-1:0] event_key;
    logic [FIELD_TAG_BITS-1:0] event_tag;
  } in_req_t;

  typedef struct packed {
    logic                      pop_valid;
    logic [FIELD_KEY_BITS-1:0] popped_key;
    logic [FIELD_TAG_BITS-1:0] popped_tag;
    logic [FIELD_OCC_BITS-1:0] occupancy;
    err_t                      error_code;
  } out_rsp_t;

  // Result register occupancy as seen by the controller.
  typedef enum logic {
    ST_EMPTY = 1'b0,
    ST_HOLD  = 1'b1
  } state_t;

  typedef struct packed {
    logic load;    // capture a new response
    logic write;   // update the queue contents
    op_t  op;
    err_t err;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } status_t;

endpackage

// ----- rtl/spq_ctrl.sv -----
// ---------------------------------------------------------------------------
// spq_ctrl: controller of the sorted priority event queue
// Tracks the response register, decides acceptance and issues commands.
// ---------------------------------------------------------------------------
module spq_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  spq_pkg::op_t     in_op,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  spq_pkg::status_t status,
  output spq_pkg::cmd_t    cmd
);

  spq_pkg::state_t state_r;
  spq_pkg::state_t state_nxt;
  logic            accept;

  // A new request is taken unless a response is waiting and still stalled.
  assign in_stall = (state_r == spq_pkg::ST_HOLD) && out_stall;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      spq_pkg::ST_EMPTY: begin
        if (accept) state_nxt = spq_pkg::ST_HOLD;
      end
      spq_pkg::ST_HOLD: begin
        if (accept) state_nxt = spq_pkg::ST_HOLD;
        else if (!out_stall) state_nxt = spq_pkg::ST_EMPTY;
      end
      default: state_nxt = spq_pkg::ST_EMPTY;
    endcase
  end

  always_comb begin
    out_valid = (state_r == spq_pkg::ST_HOLD);
    cmd.load  = accept;
    cmd.op    = in_op;
    cmd.err   = spq_pkg::ERR_NONE;
    unique case (in_op)
      spq_pkg::OP_POP:    if (status.empty) cmd.err = spq_pkg::ERR_EMPTY;
      spq_pkg::OP_INSERT: if (status.full)  cmd.err = spq_pkg::ERR_FULL;
      default:            cmd.err = spq_pkg::ERR_NONE;
    endcase
    cmd.write = accept && (cmd.err == spq_pkg::ERR_NONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= spq_pkg::ST_EMPTY;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/spq_dp.sv -----
// ---------------------------------------------------------------------------
// spq_dp: datapath of the sorted priority event queue
// A row of compare-and-shift slots holding keys and tags in ascending order,
// the entry count and the response register.
// ---------------------------------------------------------------------------
module spq_dp #(
  parameter int QUEUE_DEPTH = spq_pkg::DEF_QUEUE_DEPTH,
  parameter int KEY_BITS    = spq_pkg::DEF_KEY_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  spq_pkg::in_req_t  req,
  input  spq_pkg::cmd_t     cmd,
  output spq_pkg::status_t  status,
  output spq_pkg::out_rsp_t rsp
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int TW = spq_pkg::FIELD_TAG_BITS;

  logic [KEY_BITS-1:0] key_r   [QUEUE_DEPTH];
  logic [KEY_BITS-1:0] key_nxt [QUEUE_DEPTH];
  logic [TW-1:0]       tag_r   [QUEUE_DEPTH];
  logic [TW-1:0]       tag_nxt [QUEUE_DEPTH];
  logic [CW-1:0]       count_r;
  logic [CW-1:0]       count_nxt;
  spq_pkg::out_rsp_t   rsp_r;
  spq_pkg::out_rsp_t   rsp_nxt;

  logic [KEY_BITS-1:0]    key_in;
  logic [IW-1:0]          back_idx;
  logic                   front_case;
  logic                   back_case;
  logic [QUEUE_DEPTH-1:0] ge;
  logic [QUEUE_DEPTH-1:0] at_or_after;

  assign key_in   = KEY_BITS'(req.event_key);
  assign back_idx = IW'(count_r - CW'(1));

  assign status.empty = (count_r == '0);
  assign status.full  = (count_r == CW'(QUEUE_DEPTH));

  // Each slot decides on its own whether it sits at or behind the insert
  // position; slots past the count always count as behind it.
  always_comb begin
    front_case = (count_r == '0) || (key_in <= key_r[0]);
    back_case  = !front_case && (key_in >= key_r[back_idx]);
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      ge[i]          = (CW'(i) < count_r) && (key_r[i] >= key_in);
      at_or_after[i] = (CW'(i) >= count_r) || front_case || (!back_case && ge[i]);
    end
  end

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      key_nxt[i] = key_r[i];
      tag_nxt[i] = tag_r[i];
    end
    count_nxt = count_r;
    if (cmd.write) begin
      if (cmd.op == spq_pkg::OP_POP) begin
        for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
          key_nxt[i] = key_r[i+1];
          tag_nxt[i] = tag_r[i+1];
        end
        count_nxt = count_r - CW'(1);
      end else begin
        if (at_or_after[0]) begin
          key_nxt[0] = key_in;
          tag_nxt[0] = req.event_tag;
        end
        for (int i = 1; i < QUEUE_DEPTH; i++) begin
          if (at_or_after[i] && !at_or_after[i-1]) begin
            key_nxt[i] = key_in;
            tag_nxt[i] = req.event_tag;
          end else if (at_or_after[i]) begin
            key_nxt[i] = key_r[i-1];
            tag_nxt[i] = tag_r[i-1];
          end
        end
        count_nxt = count_r + CW'(1);
      end
    end
  end

  always_comb begin
    rsp_nxt            = rsp_r;
    if (cmd.load) begin
      rsp_nxt.pop_valid  = cmd.write && (cmd.op == spq_pkg::OP_POP);
      rsp_nxt.popped_key = '0;
      rsp_nxt.popped_tag = '0;
      if (rsp_nxt.pop_valid) begin
        rsp_nxt.popped_key = spq_pkg::FIELD_KEY_BITS'(key_r[0]);
        rsp_nxt.popped_tag = tag_r[0];
      end
      rsp_nxt.occupancy  = spq_pkg::FIELD_OCC_BITS'(count_nxt);
      rsp_nxt.error_code = cmd.err;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      key_r[i] <= key_nxt[i];
      tag_r[i] <= tag_nxt[i];
    end
    rsp_r <= rsp_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign rsp = rsp_r;

endmodule

// ----- rtl/sorted_priority_event_queue.sv -----
// ---------------------------------------------------------------------------
// sorted_priority_event_queue: bounded priority queue sorted by time key
// Top level joining the acceptance controller and the slot datapath.
// ---------------------------------------------------------------------------
// Usage. The in_ channel carries one request per handshake: an insert with a
// key and a tag, or a pop. A request is taken at a rising edge where
// in_valid is high and in_stall is low. Every request gives exactly one
// response on the out_ channel, taken where out_valid is high and out_stall
// is low.
// The response is captured in the output register at the same edge that
// takes the request. Throughput is one request per cycle while no waiting
// response is stalled, set by the row of compare-and-shift slots, where every
// slot compares its key with the new key in parallel and moves in one step.
// While a response is waiting and the receiver stalls, in_stall is raised
// and the waiting response holds steady; as soon as out_stall drops, a new
// request may be taken in the same cycle the old response leaves.
// Reset empties the queue and the output register at once; slot contents
// are not cleared, since only slots below the entry count are ever read.
// Popping an empty queue or inserting into a full queue reports an error
// code and leaves the queue untouched.
// ---------------------------------------------------------------------------
module sorted_priority_event_queue #(
  parameter int QUEUE_DEPTH = spq_pkg::DEF_QUEUE_DEPTH,
  parameter int KEY_BITS    = spq_pkg::DEF_KEY_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  spq_pkg::in_req_t  in_req,
  output logic              out_valid,
  input  logic              out_stall,
  output spq_pkg::out_rsp_t out_rsp
);

  spq_pkg::cmd_t    cmd;
  spq_pkg::status_t status;

  // The controller owns acceptance and the response register's handshake.
  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_req.opcode),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // The datapath holds the sorted slots, the count and the response.
  spq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .KEY_BITS    (KEY_BITS)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (in_req),
    .cmd    (cmd),
    .status (status),
    .rsp    (out_rsp)
  );

endmodule
